// ===== sv/msm_pkg.sv =====
// shared types and field widths of the multibuffer slot manager
package msm_pkg;

	localparam int MODE_W     = 3;
	localparam int SLOT_W     = 4;
	localparam int FRAME_W    = 64;
	localparam int RSLOT_W    = 3;
	localparam int REFO_W     = 16;
	localparam int FREE_W     = 4;
	localparam int CNT_W      = 32;
	localparam int BCNT_W     = 4;
	localparam logic [BCNT_W-1:0] BCNT_RESET = 4'd3;

	typedef enum logic [MODE_W-1:0] {
		MODE_ACQ_BACK  = 3'd0,
		MODE_PUBLISH   = 3'd1,
		MODE_ACQ_FRONT = 3'd2,
		MODE_ACQ_PREV  = 3'd3,
		MODE_RELEASE   = 3'd4,
		MODE_QUERY     = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_PLAN,
		ST_RD,
		ST_WR,
		ST_COUNT,
		ST_FIN
	} state_t;

endpackage

// ===== sv/msm_cmd_if.sv =====
// command channel of the slot manager
interface msm_cmd_if;
	import msm_pkg::*;

	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [SLOT_W-1:0]  slot;
	logic [FRAME_W-1:0] frame_index;

	modport source (output valid, mode, slot, frame_index, input ready);
	modport sink (input valid, mode, slot, frame_index, output ready);

endinterface

// ===== sv/msm_rsp_if.sv =====
// result channel of the slot manager
interface msm_rsp_if;
	import msm_pkg::*;

	logic               valid;
	logic               ready;
	logic [RSLOT_W-1:0] result_slot;
	logic               result_valid;
	logic [REFO_W-1:0]  slot_ref_count;
	logic [FREE_W-1:0]  free_slots;
	logic [CNT_W-1:0]   skip_total;
	logic [CNT_W-1:0]   stall_total;
	logic [FRAME_W-1:0] frame_age;

	modport source (output valid, result_slot, result_valid, slot_ref_count, free_slots,
		skip_total, stall_total, frame_age, input ready);
	modport sink (input valid, result_slot, result_valid, slot_ref_count, free_slots,
		skip_total, stall_total, frame_age, output ready);

endinterface

// ===== sv/msm_slot_mem.sv =====
// per-slot state memory, one write and one registered read port, zero until written
module msm_slot_mem #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 81,
	parameter int AW    = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= valid_q[raddr] ? mem[raddr] : '0;
		end
	end

	// entries read as zero until their first write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/multibuffer_slot_manager_top.sv =====
// slot manager for a pool of frame buffers shared by one producer and one consumer
//
//   channel   | dir | handshake        | payload
//   ----------+-----+------------------+------------------------------------------------
//   cmd       | in  | valid / ready    | mode, slot, frame_index
//   rsp       | out | valid / ready    | result_slot, result_valid, slot_ref_count,
//             |     |                  | free_slots, skip_total, stall_total, frame_age
//   cfg       | in  | cfg_we           | cfg_wdata (buffer_count)
//
// one command at a time; each walk reads entries 0..n-1 via the registered read port, n
// being the clamped buffer count. acquire back with n above one runs a drain walk, a
// read-modify-write and a free-count walk; other cases skip the drain walk, and one
// that touches no entry skips the read-modify-write too. the result sits in an output
// register, so the next command is taken while it waits. reset clears the slot memory at
// once via per-entry valid bits, no clearing pass; a stalled rsp holds only the final step.
module multibuffer_slot_manager_top #(
	parameter int MAX_SLOTS = 8,
	parameter int REF_BITS  = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	msm_cmd_if.sink                     cmd,
	msm_rsp_if.source                   rsp,
	input  logic                        cfg_we,
	input  logic [msm_pkg::BCNT_W-1:0]  cfg_wdata
);
	import msm_pkg::*;

	localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int NW = $clog2(MAX_SLOTS + 1);
	localparam int CW = (NW > SLOT_W) ? NW : SLOT_W;

	typedef struct packed {
		logic                reclaim;
		logic [REF_BITS-1:0] refs;
		logic [FRAME_W-1:0]  frame;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);

	state_t state_q, state_d;

	logic [BCNT_W-1:0]  bc_q;
	mode_t              mode_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [FRAME_W-1:0] frame_q;
	logic [NW-1:0]      n_q;
	logic [NW-1:0]      n_in;

	logic [SLOT_W-1:0]  front_q, prev_q, back_q;
	logic               front_v_q, prev_v_q, back_v_q;
	logic [FRAME_W-1:0] pub_q, cons_q, age_q;
	logic [CNT_W-1:0]   skip_q, stall_q;

	logic               found_q, back_z_q;
	logic [AW-1:0]      first_q;
	logic               ok_q;
	logic [AW-1:0]      tgt_q;
	logic [REF_BITS-1:0] refs_out_q;
	logic [NW-1:0]      free_cnt_q;

	logic [NW-1:0]      idx_q;
	logic               pend_s1;
	logic [AW-1:0]      pidx_s1;

	logic               rsp_valid_q;
	logic [RSLOT_W-1:0] rsp_slot_q;
	logic               rsp_ok_q;
	logic [REFO_W-1:0]  rsp_refs_q;
	logic [FREE_W-1:0]  rsp_free_q;
	logic [CNT_W-1:0]   rsp_skip_q, rsp_stall_q;
	logic [FRAME_W-1:0] rsp_age_q;

	logic               mem_we, mem_re;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	ent_t               mem_wdata;
	logic [ENT_W-1:0]   mem_rdata;
	ent_t               ent_r;

	logic               scan_issue, scan_done;
	logic               front_hit_p, back_hit_p, refs0_p, drain_p, free_drain_p, free_cnt_p;
	logic               slot_in, front_in, prev_in, n_one, skip_inc;
	logic [SLOT_W-1:0]  psel;
	logic               plan_ok, plan_has;
	logic [AW-1:0]      plan_tgt;
	logic [REF_BITS-1:0] refs_new;
	logic               wr_we;
	ent_t               wr_ent;
	logic [FRAME_W:0]   age_diff;
	logic [REF_BITS+REFO_W-1:0] refs_wide;
	logic               out_load;

	msm_slot_mem #(
		.DEPTH (MAX_SLOTS),
		.WIDTH (ENT_W),
		.AW    (AW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata)
	);

	assign ent_r = ent_t'(mem_rdata);

	// clamp the buffer count to 1..MAX_SLOTS
	always_comb begin
		if (bc_q == '0) begin
			n_in = NW'(1);
		end else if (CW'(bc_q) > CW'(MAX_SLOTS)) begin
			n_in = NW'(MAX_SLOTS);
		end else begin
			n_in = NW'(bc_q);
		end
	end

	assign scan_issue = ((state_q == ST_DRAIN) || (state_q == ST_COUNT)) && (idx_q < n_q);
	assign scan_done  = !scan_issue && !pend_s1;

	// classification of the entry returned by the walk
	assign front_hit_p  = front_v_q && (front_q == SLOT_W'(pidx_s1));
	assign back_hit_p   = back_v_q && (back_q == SLOT_W'(pidx_s1));
	assign refs0_p      = (ent_r.refs == '0);
	assign drain_p      = ent_r.reclaim && !front_hit_p && refs0_p;
	assign free_drain_p = !(ent_r.reclaim && !drain_p) && !front_hit_p && !back_hit_p && refs0_p;
	assign free_cnt_p   = !ent_r.reclaim && !front_hit_p && !back_hit_p && refs0_p;

	assign slot_in  = CW'(slot_q) < CW'(n_q);
	assign front_in = front_v_q && (CW'(front_q) < CW'(n_q));
	assign psel     = prev_v_q ? prev_q : front_q;
	assign prev_in  = (prev_v_q || front_v_q) && (CW'(psel) < CW'(n_q));
	assign n_one    = (n_q == NW'(1));
	assign skip_inc = (mode_q == MODE_ACQ_BACK) && !n_one && !found_q;

	always_comb begin
		plan_ok  = 1'b0;
		plan_has = 1'b0;
		plan_tgt = AW'(slot_q);
		case (mode_q)
			MODE_ACQ_BACK: begin
				if (n_one) begin
					plan_ok  = 1'b1;
					plan_tgt = '0;
				end else if (found_q) begin
					plan_ok  = 1'b1;
					plan_tgt = first_q;
				end else if (back_v_q && back_z_q) begin
					// back_z_q is only set when the back slot lies below n
					plan_ok  = 1'b1;
					plan_tgt = AW'(back_q);
				end
				plan_has = plan_ok;
			end
			MODE_ACQ_FRONT: begin
				plan_ok  = front_in;
				plan_has = front_in;
				plan_tgt = AW'(front_q);
			end
			MODE_ACQ_PREV: begin
				plan_ok  = prev_in;
				plan_has = prev_in;
				plan_tgt = AW'(psel);
			end
			default: begin
				plan_has = slot_in;
			end
		endcase
	end

	// modify step on the target entry
	always_comb begin
		wr_ent   = ent_r;
		wr_we    = 1'b0;
		refs_new = ent_r.refs;
		case (mode_q)
			MODE_ACQ_BACK: begin
				wr_ent.reclaim = 1'b0;
				wr_ent.frame   = frame_q;
				wr_we          = 1'b1;
			end
			MODE_ACQ_FRONT, MODE_ACQ_PREV: begin
				if (ent_r.refs != '1) begin
					refs_new = ent_r.refs + REF_BITS'(1);
				end
				wr_ent.refs = refs_new;
				wr_we       = 1'b1;
			end
			MODE_RELEASE: begin
				if (ent_r.refs != '0) begin
					refs_new    = ent_r.refs - REF_BITS'(1);
					wr_ent.refs = refs_new;
					if (refs_new == '0 && !(front_v_q && front_q == slot_q)) begin
						wr_ent.reclaim = 1'b1;
					end
					wr_we = 1'b1;
				end
			end
			default: begin
				wr_we = 1'b0;
			end
		endcase
	end

	assign age_diff  = {1'b0, frame_q} - {1'b0, ent_r.frame};
	assign refs_wide = {REFO_W'(0), refs_out_q};

	always_comb begin
		mem_re    = scan_issue || (state_q == ST_RD);
		mem_raddr = (state_q == ST_RD) ? tgt_q : idx_q[AW-1:0];
		if (state_q == ST_WR) begin
			mem_we    = wr_we;
			mem_waddr = tgt_q;
			mem_wdata = wr_ent;
		end else begin
			mem_we    = (state_q == ST_DRAIN) && pend_s1 && drain_p;
			mem_waddr = pidx_s1;
			mem_wdata = ent_r;
			mem_wdata.reclaim = 1'b0;
		end
	end

	assign out_load = (state_q == ST_FIN) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					if (mode_t'(cmd.mode) == MODE_ACQ_BACK && n_in != NW'(1)) begin
						state_d = ST_DRAIN;
					end else begin
						state_d = ST_PLAN;
					end
				end
			end
			ST_DRAIN: begin
				if (scan_done) begin
					state_d = ST_PLAN;
				end
			end
			ST_PLAN: begin
				state_d = plan_has ? ST_RD : ST_COUNT;
			end
			ST_RD: begin
				state_d = ST_WR;
			end
			ST_WR: begin
				state_d = ST_COUNT;
			end
			ST_COUNT: begin
				if (scan_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q <= BCNT_RESET;
		end else if (cfg_we) begin
			bc_q <= cfg_wdata;
		end
	end

	// command beat and walk bookkeeping
	always_ff @(posedge clk) begin
		pend_s1 <= scan_issue;
		pidx_s1 <= idx_q[AW-1:0];
		if (scan_issue) begin
			idx_q <= idx_q + NW'(1);
		end
		case (state_q)
			ST_IDLE: begin
				mode_q     <= mode_t'(cmd.mode);
				slot_q     <= cmd.slot;
				frame_q    <= cmd.frame_index;
				n_q        <= n_in;
				idx_q      <= '0;
				found_q    <= 1'b0;
				back_z_q   <= 1'b0;
			end
			ST_DRAIN: begin
				if (pend_s1) begin
					if (free_drain_p && !found_q) begin
						found_q <= 1'b1;
						first_q <= pidx_s1;
					end
					if (back_hit_p) begin
						back_z_q <= refs0_p;
					end
				end
			end
			ST_PLAN: begin
				ok_q       <= plan_ok;
				tgt_q      <= plan_tgt;
				refs_out_q <= '0;
				idx_q      <= '0;
				free_cnt_q <= '0;
			end
			ST_WR: begin
				refs_out_q <= refs_new;
			end
			ST_COUNT: begin
				if (pend_s1 && free_cnt_p) begin
					free_cnt_q <= free_cnt_q + NW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// buffer roles, sequences and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q   <= '0;
			front_v_q <= 1'b0;
			prev_q    <= '0;
			prev_v_q  <= 1'b0;
			back_q    <= '0;
			back_v_q  <= 1'b0;
			pub_q     <= '0;
			cons_q    <= '0;
			skip_q    <= '0;
			stall_q   <= '0;
			age_q     <= '0;
		end else if (state_q == ST_PLAN) begin
			if (skip_inc && skip_q != '1) begin
				skip_q <= skip_q + CNT_W'(1);
			end
			case (mode_q)
				MODE_ACQ_BACK: begin
					if (plan_ok) begin
						back_q   <= SLOT_W'(plan_tgt);
						back_v_q <= 1'b1;
					end
				end
				MODE_PUBLISH: begin
					if (slot_in) begin
						prev_q    <= front_q;
						prev_v_q  <= front_v_q;
						front_q   <= slot_q;
						front_v_q <= 1'b1;
						pub_q     <= pub_q + FRAME_W'(1);
						if (back_v_q && back_q == slot_q) begin
							back_v_q <= 1'b0;
						end
					end
				end
				MODE_ACQ_FRONT: begin
					if (plan_ok) begin
						if (pub_q == cons_q && stall_q != '1) begin
							stall_q <= stall_q + CNT_W'(1);
						end
						cons_q <= pub_q;
					end
				end
				MODE_ACQ_PREV: begin
					if (plan_ok) begin
						cons_q <= pub_q;
					end
				end
				default: begin
				end
			endcase
		end else if (state_q == ST_WR) begin
			if (mode_q == MODE_ACQ_FRONT || mode_q == MODE_ACQ_PREV) begin
				// age floors at zero when the stored frame is newer
				age_q <= age_diff[FRAME_W] ? '0 : age_diff[FRAME_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_slot_q  <= ok_q ? RSLOT_W'(tgt_q) : '0;
			rsp_ok_q    <= ok_q;
			rsp_refs_q  <= refs_wide[REFO_W-1:0];
			rsp_free_q  <= FREE_W'(free_cnt_q);
			rsp_skip_q  <= skip_q;
			rsp_stall_q <= stall_q;
			rsp_age_q   <= age_q;
		end
	end

	assign cmd.ready          = (state_q == ST_IDLE);
	assign rsp.valid          = rsp_valid_q;
	assign rsp.result_slot    = rsp_slot_q;
	assign rsp.result_valid   = rsp_ok_q;
	assign rsp.slot_ref_count = rsp_refs_q;
	assign rsp.free_slots     = rsp_free_q;
	assign rsp.skip_total     = rsp_skip_q;
	assign rsp.stall_total    = rsp_stall_q;
	assign rsp.frame_age      = rsp_age_q;

endmodule
